### hw/rtl/sse_pkg.sv
package sse_pkg;

  localparam int unsigned Depth  = 64;
  localparam int unsigned IdxW   = $clog2(Depth);
  localparam int unsigned CntW   = $clog2(Depth + 1);
  localparam int unsigned ValueW = 32;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef logic signed [ValueW-1:0] value_t;

  typedef enum logic [2:0] {
    StLoad = 3'b001,
    StScan = 3'b010,
    StSwap = 3'b100
  } state_e;

endpackage

### hw/rtl/sse_ram.sv
module sse_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/sse_cmp.sv
// Shared order compare: high when cand_i must come ahead of best_i.
module sse_cmp (
  input  sse_pkg::value_t cand_i,
  input  sse_pkg::value_t best_i,
  input  logic            descending_i,
  output logic            before_o
);

  assign before_o = descending_i ? (cand_i > best_i) : (cand_i < best_i);

endmodule

### hw/rtl/selection_sort_engine_core.sv
// Selection sort engine.
// Input channel (in_valid_i / in_ready_o): one signed 32-bit value per
// transfer, last_in_i marks the final value of a set. Values are written
// into a 64-entry RAM; a value that arrives while the RAM is full is
// dropped and the set is flagged, a dropped value with last_in_i still
// closes the set. in_ready_o is high exactly while loading.
// After the closing transfer the core sorts n values with one comparator:
// pass k streams RAM entries k..n-1 through the comparator (one per cycle,
// read from the registered RAM output) and then enters the swap state that
// emits the winner and moves entry k into the winner's slot. Sort speed is
// bounded by the single RAM read port.
// Output channel (out_valid_o / out_ready_i): results leave in ascending or
// descending order (cfg register, written via cfg_we_i; the user must write
// it only while idle, the core does not enforce this), with last_out_o on
// the final one and overflow_o on every result of a dropped set. A stalled
// receiver holds the output register and the core waits in its swap state.
// Reset (rst_ni, async, active low) empties the set and selects ascending.
module selection_sort_engine_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  sse_pkg::value_t        value_i,
  input  logic                   last_in_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output sse_pkg::value_t        sorted_value_o,
  output logic                   last_out_o,
  output logic                   overflow_o
);

  sse_pkg::state_e state_q, state_d;
  logic            desc_q;
  sse_pkg::cnt_t   count_q, count_d;
  logic            dropped_q, dropped_d;
  sse_pkg::cnt_t   n_q, n_d;
  sse_pkg::idx_t   pass_q, pass_d;      // current pass (slot being filled)
  sse_pkg::cnt_t   rd_idx_q, rd_idx_d;  // next read address to issue
  sse_pkg::idx_t   cmp_idx_q, cmp_idx_d;
  logic            data_vld_q, data_vld_d;
  sse_pkg::value_t best_q, best_d;
  sse_pkg::idx_t   best_idx_q, best_idx_d;
  sse_pkg::value_t head_q, head_d;      // original value of the pass slot

  logic            out_valid_q, out_valid_d;
  sse_pkg::value_t out_value_q, out_value_d;
  logic            out_last_q, out_last_d;
  logic            out_ovf_q, out_ovf_d;

  logic            ram_we;
  sse_pkg::idx_t   ram_waddr;
  sse_pkg::value_t ram_wdata;
  sse_pkg::idx_t   ram_raddr;
  logic [sse_pkg::ValueW-1:0] ram_rdata;
  sse_pkg::value_t rd_value;

  logic in_xfer;
  logic issue;
  logic cand_wins;
  logic first_of_pass;
  logic scan_end;
  logic last_pass;
  logic out_free;
  logic has_room;

  sse_ram #(
    .Width (sse_pkg::ValueW),
    .Depth (sse_pkg::Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_value = sse_pkg::value_t'(ram_rdata);

  sse_cmp u_cmp (
    .cand_i       (rd_value),
    .best_i       (best_q),
    .descending_i (desc_q),
    .before_o     (cand_wins)
  );

  assign in_ready_o    = (state_q == sse_pkg::StLoad);
  assign in_xfer       = in_valid_i && in_ready_o;
  assign has_room      = (count_q < sse_pkg::cnt_t'(sse_pkg::Depth));
  assign issue         = (state_q == sse_pkg::StScan) && (rd_idx_q < n_q);
  assign ram_raddr     = rd_idx_q[sse_pkg::IdxW-1:0];
  assign first_of_pass = (cmp_idx_q == pass_q);
  assign scan_end      = ({1'b0, cmp_idx_q} == n_q - sse_pkg::cnt_t'(1));
  assign last_pass     = ({1'b0, pass_q} == n_q - sse_pkg::cnt_t'(1));
  assign out_free      = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    dropped_d   = dropped_q;
    n_d         = n_q;
    pass_d      = pass_q;
    rd_idx_d    = rd_idx_q;
    cmp_idx_d   = cmp_idx_q;
    data_vld_d  = 1'b0;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    head_d      = head_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    ram_we      = 1'b0;
    ram_waddr   = count_q[sse_pkg::IdxW-1:0];
    ram_wdata   = value_i;

    unique case (state_q)
      sse_pkg::StLoad: begin
        if (in_xfer) begin
          // store while there is room, otherwise drop and flag the set
          if (has_room) begin
            ram_we  = 1'b1;
            count_d = count_q + sse_pkg::cnt_t'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (last_in_i) begin
            n_d      = has_room ? count_q + sse_pkg::cnt_t'(1) : count_q;
            pass_d   = '0;
            rd_idx_d = '0;
            state_d  = sse_pkg::StScan;
          end
        end
      end
      sse_pkg::StScan: begin
        if (issue) begin
          rd_idx_d   = rd_idx_q + sse_pkg::cnt_t'(1);
          cmp_idx_d  = ram_raddr;
          data_vld_d = 1'b1;
        end
        if (data_vld_q) begin
          if (first_of_pass) begin
            best_d     = rd_value;
            best_idx_d = cmp_idx_q;
            head_d     = rd_value;
          end else if (cand_wins) begin
            best_d     = rd_value;
            best_idx_d = cmp_idx_q;
          end
          if (scan_end) begin
            state_d = sse_pkg::StSwap;
          end
        end
      end
      sse_pkg::StSwap: begin
        // hold until the output register is free, then emit and swap
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = best_q;
          out_last_d  = last_pass;
          out_ovf_d   = dropped_q;
          ram_we      = 1'b1;
          ram_waddr   = best_idx_q;
          ram_wdata   = head_q;
          if (last_pass) begin
            count_d   = '0;
            dropped_d = 1'b0;
            state_d   = sse_pkg::StLoad;
          end else begin
            pass_d   = pass_q + sse_pkg::idx_t'(1);
            rd_idx_d = {1'b0, pass_q} + sse_pkg::cnt_t'(1);
            state_d  = sse_pkg::StScan;
          end
        end
      end
      default: begin
        state_d = sse_pkg::StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sse_pkg::StLoad;
      desc_q      <= 1'b0;
      count_q     <= '0;
      dropped_q   <= 1'b0;
      n_q         <= '0;
      pass_q      <= '0;
      rd_idx_q    <= '0;
      data_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        desc_q <= cfg_wdata_i;
      end
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      n_q         <= n_d;
      pass_q      <= pass_d;
      rd_idx_q    <= rd_idx_d;
      data_vld_q  <= data_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q   <= cmp_idx_d;
    best_q      <= best_d;
    best_idx_q  <= best_idx_d;
    head_q      <= head_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_value_q;
  assign last_out_o     = out_last_q;
  assign overflow_o     = out_ovf_q;

endmodule

### tb/sv/tb_selection_sort_engine_core.sv
`timescale 1ns / 1ps

module tb_selection_sort_engine_core;

  // Pause the receiver this long once so the core fills up and stalls its input.
  localparam int unsigned HoldCycles    = 600;
  // End the run when no transfer happens on either channel for this long.
  localparam int unsigned WatchdogLimit = 4000;
  // Least number of random items per order phase.
  localparam int unsigned PhaseItems    = 85;
  // Let the final swap cycle retire before touching the order register.
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned TailCycles    = 20;
  localparam int unsigned NumRows       = 17;

  localparam sse_pkg::value_t MinVal  = sse_pkg::value_t'(32'h8000_0000);
  localparam sse_pkg::value_t MaxVal  = sse_pkg::value_t'(32'h7fff_ffff);
  localparam sse_pkg::value_t Minus1  = sse_pkg::value_t'(32'hffff_ffff);
  localparam sse_pkg::value_t OldStop = sse_pkg::value_t'(-999);

  // One result of a closed set, in the order the core must emit it.
  typedef struct packed {
    sse_pkg::value_t val;
    logic            last;
    logic            ovf;
  } sorted_t;

  // One row of the directed table. Rows marked known are one-value sets whose
  // result can be typed in directly; all other rows go through the predictor.
  typedef struct packed {
    sse_pkg::value_t val;
    logic            last;
    logic            known;
    sse_pkg::value_t want;
  } row_t;

  localparam row_t DirRows [NumRows] = '{
    // single-value sets: zero, both extremes, the old list stopper, all ones
    '{32'sd0,  1'b1, 1'b1, 32'sd0},
    '{MaxVal,  1'b1, 1'b1, MaxVal},
    '{MinVal,  1'b1, 1'b1, MinVal},
    '{OldStop, 1'b1, 1'b1, OldStop},
    '{Minus1,  1'b1, 1'b1, Minus1},
    // mixed set with both extremes, a duplicate and -999 in the middle
    '{32'sd5,  1'b0, 1'b0, 32'sd0},
    '{-32'sd3, 1'b0, 1'b0, 32'sd0},
    '{MaxVal,  1'b0, 1'b0, 32'sd0},
    '{MinVal,  1'b0, 1'b0, 32'sd0},
    '{OldStop, 1'b0, 1'b0, 32'sd0},
    '{32'sd5,  1'b0, 1'b0, 32'sd0},
    '{32'sd0,  1'b1, 1'b0, 32'sd0},
    // two-value set, sent ascending (reverse order for the descending walk)
    '{MinVal,  1'b0, 1'b0, 32'sd0},
    '{MaxVal,  1'b1, 1'b0, 32'sd0},
    // all-equal set
    '{OldStop, 1'b0, 1'b0, 32'sd0},
    '{OldStop, 1'b0, 1'b0, 32'sd0},
    '{OldStop, 1'b1, 1'b0, 32'sd0}
  };

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic            cfg_wdata_i;
  logic            in_valid_i;
  logic            in_ready_o;
  sse_pkg::value_t value_i;
  logic            last_in_i;
  logic            out_valid_o;
  logic            out_ready_i;
  sse_pkg::value_t sorted_value_o;
  logic            last_out_o;
  logic            overflow_o;

  // Predictor state: the set being collected and the current order.
  sse_pkg::value_t set_vals [sse_pkg::Depth];
  int              set_len     = 0;
  logic            set_dropped = 1'b0;
  logic            sort_desc   = 1'b0;

  // Results owed by the core, oldest first.
  sorted_t sorted_due [$];

  int      err_count    = 0;
  int      stall_cycles = 0;
  logic    hold_req     = 1'b0;
  logic    no_idle      = 1'b0;

  selection_sort_engine_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .value_i        (value_i),
    .last_in_i      (last_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sorted_value_o (sorted_value_o),
    .last_out_o     (last_out_o),
    .overflow_o     (overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string field, sse_pkg::value_t want,
                                 sse_pkg::value_t seen);
    err_count++;
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, field, want, seen);
  endtask

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Mostly small sets; a few come near or fill the store exactly, or spill past it.
  function automatic int pick_set_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 85) return $urandom_range(9, 40);
    if (r < 93) return $urandom_range(sse_pkg::Depth - 4, sse_pkg::Depth);
    return $urandom_range(sse_pkg::Depth + 1, sse_pkg::Depth + 8);
  endfunction

  // Mix full-range values with a narrow band (for duplicates) and the extremes.
  function automatic sse_pkg::value_t random_value();
    case ($urandom_range(0, 3))
      0: return sse_pkg::value_t'(int'($urandom_range(0, 20)) - 10);
      1: begin
        case ($urandom_range(0, 4))
          0: return MinVal;
          1: return MaxVal;
          2: return Minus1;
          3: return OldStop;
          default: return '0;
        endcase
      end
      default: return sse_pkg::value_t'($urandom);
    endcase
  endfunction

  // Collect one value; on the closing value sort the set and queue its results.
  task automatic absorb_value(sse_pkg::value_t v, logic last);
    int              best;
    sse_pkg::value_t tmp;
    if (set_len < sse_pkg::Depth) begin
      set_vals[set_len] = v;
      set_len++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!last) return;
    for (int i = 0; i + 1 < set_len; i++) begin
      best = i;
      for (int j = i + 1; j < set_len; j++) begin
        if (sort_desc ? (set_vals[j] > set_vals[best]) : (set_vals[j] < set_vals[best]))
          best = j;
      end
      tmp            = set_vals[i];
      set_vals[i]    = set_vals[best];
      set_vals[best] = tmp;
    end
    for (int k = 0; k < set_len; k++)
      sorted_due.push_back(sorted_t'{set_vals[k], k == set_len - 1, set_dropped});
    set_len     = 0;
    set_dropped = 1'b0;
  endtask

  // Offer one value and return at the edge of its transfer. Valid stays high
  // on return so the next call can follow back to back; callers drop it.
  task automatic send_item(sse_pkg::value_t v, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    last_in_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Change the sort order only with no set open and nothing owed.
  task automatic write_order(logic desc);
    in_valid_i <= 1'b0;
    while (sorted_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= desc;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    sort_desc = desc;
  endtask

  task automatic play_rows();
    for (int i = 0; i < NumRows; i++) begin
      send_item(DirRows[i].val, DirRows[i].last);
      absorb_value(DirRows[i].val, DirRows[i].last);
      // Swap in the hand-written result for one-value sets.
      if (DirRows[i].known) begin
        void'(sorted_due.pop_back());
        sorted_due.push_back(sorted_t'{DirRows[i].want, 1'b1, 1'b0});
      end
    end
  endtask

  // Receiver: random ready pattern, plus one long hold-off on request.
  initial begin : ready_gen
    int run;
    int gap;
    out_ready_i = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        run = no_idle ? 50 : $urandom_range(1, 12);
        out_ready_i <= 1'b1;
        repeat (run) @(posedge clk_i);
        gap = pick_gap();
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  // Check every output transfer against the oldest owed result.
  always @(posedge clk_i) begin : check_out
    sorted_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sorted_due.size() == 0) begin
        report_mismatch("unowed result", '0, sorted_value_o);
      end else begin
        want = sorted_due.pop_front();
        if (sorted_value_o !== want.val)
          report_mismatch("sorted_value", want.val, sorted_value_o);
        if (last_out_o !== want.last)
          report_mismatch("last_out", sse_pkg::value_t'({31'b0, want.last}),
                          sse_pkg::value_t'({31'b0, last_out_o}));
        if (overflow_o !== want.ovf)
          report_mismatch("overflow", sse_pkg::value_t'({31'b0, want.ovf}),
                          sse_pkg::value_t'({31'b0, overflow_o}));
      end
    end
  end

  // Watchdog: count cycles without a transfer on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WatchdogLimit) begin
      $display("[%0t] watchdog: no transfer for %0d cycles, %0d results owed",
               $realtime, stall_cycles, sorted_due.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int              n;
    int              done_items;
    sse_pkg::value_t v;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    in_valid_i  = 1'b0;
    value_i     = '0;
    last_in_i   = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table once per order.
    write_order(1'b0);
    play_rows();
    write_order(1'b1);
    play_rows();

    // Random phases alternate the order. Phase 0 opens with a set one past
    // capacity (last value dropped), phase 1 with an exactly full set.
    // Phase 1 runs without idling, phase 2 starts with the long hold-off.
    for (int phase = 0; phase < 4; phase++) begin
      write_order(phase % 2 == 0);
      no_idle = (phase == 1);
      if (phase == 2) hold_req = 1'b1;
      done_items = 0;
      n = (phase == 0) ? sse_pkg::Depth + 1 : (phase == 1) ? sse_pkg::Depth : pick_set_len();
      while (done_items < PhaseItems) begin
        for (int k = 0; k < n; k++) begin
          v = random_value();
          send_item(v, k == n - 1);
          absorb_value(v, k == n - 1);
        end
        done_items += n;
        n = pick_set_len();
      end
    end
    no_idle = 1'b0;
    in_valid_i <= 1'b0;

    // Drain, then wait out TailCycles so the core can show any stray result.
    while (sorted_due.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (err_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

### files.f
hw/rtl/sse_pkg.sv
hw/rtl/sse_ram.sv
hw/rtl/sse_cmp.sv
hw/rtl/selection_sort_engine_core.sv
tb/sv/tb_selection_sort_engine_core.sv
